[src/focc_pkg.sv]
// Shared widths, constants and types for the flow offset to RGB color pipeline.
// Used by every module of the block; depends on nothing.

package focc_pkg;

  // Width of one signed displacement field.
  localparam int unsigned OFFSET_BITS = 12;

  localparam int unsigned ABS_W   = OFFSET_BITS;            // |offset| up to 2^(W-1)
  localparam int unsigned L2_W    = 2 * OFFSET_BITS;        // squared length
  localparam int unsigned ROOT_W  = OFFSET_BITS + 16;       // isqrt(l2 * 2^32)
  localparam int unsigned SQREM_W = ROOT_W + 3;             // square root remainder
  localparam int unsigned XY_W    = OFFSET_BITS + 19;       // CORDIC x and y, signed
  localparam int unsigned Z_W     = 25;                     // angle accumulator, deg Q16
  localparam int unsigned ANG_W   = 15;                     // quadrant angle, deg Q8
  localparam int unsigned HUE_W   = 17;                     // hue, deg Q8
  localparam int unsigned S_W     = 17;                     // 0.16 fraction incl. 1.0
  localparam int unsigned F_W     = 16;                     // 0.16 fraction below 1.0
  localparam int unsigned QUO_BITS = 17;
  localparam int unsigned RAD_W   = 12;
  localparam int unsigned DREM_W  = RAD_W + 1;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned NUM_W   = 20;                     // remainder * 64
  localparam int unsigned RCP_W   = 21;

  localparam int unsigned CORDIC_STEPS = 16;

  // Pipeline depths in register stages.
  localparam int unsigned LAT_ANGLE = CORDIC_STEPS + 3;
  localparam int unsigned LAT_SAT   = ROOT_W + QUO_BITS + 3;
  localparam int unsigned LAT_COLOR = 6;
  localparam int unsigned HUE_DLY   = LAT_SAT - LAT_ANGLE;
  localparam int unsigned LAT_TOTAL = LAT_SAT + LAT_COLOR + 1;

  localparam logic [Z_W-1:0] Z_MAX_DEG90 = 25'd5898240;
  localparam logic [Z_W-1:0] Z_HALF_LSB  = 25'd128;

  localparam logic [ANG_W-1:0] ANG_Q8_90 = 15'd23040;

  localparam logic [HUE_W-1:0] DEG_Q8_60  = 17'd15360;
  localparam logic [HUE_W-1:0] DEG_Q8_120 = 17'd30720;
  localparam logic [HUE_W-1:0] DEG_Q8_180 = 17'd46080;
  localparam logic [HUE_W-1:0] DEG_Q8_240 = 17'd61440;
  localparam logic [HUE_W-1:0] DEG_Q8_300 = 17'd76800;
  localparam logic [HUE_W-1:0] DEG_Q8_360 = 17'd92160;

  localparam logic [S_W-1:0] ONE_Q16 = 17'd65536;

  // floor(2^24 / 15): f = floor(rem * 64 / 15) with one correction step.
  localparam logic [RCP_W-1:0] RECIP_15 = 21'd1118481;
  localparam logic [NUM_W-1:0] FIFTEEN  = 20'd15;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 12'd40;
  localparam logic [LVL_W-1:0] LEVEL_RESET  = 8'd204;

  // atan(2^-i) in degrees with 16 fraction bits.
  localparam logic [Z_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    25'd2949120, 25'd1740967, 25'd919879, 25'd466945,
    25'd234379,  25'd117304,  25'd58666,  25'd29335,
    25'd14668,   25'd7334,    25'd3667,   25'd1833,
    25'd917,     25'd458,     25'd229,    25'd115
  };

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_LEVEL  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic dy_zero;
  } quad_t;

endpackage

[src/flow_offset_to_rgb_color.sv]
// Top level: register port, input stage, hue and saturation pipelines and
// the HSV to RGB stage. Depends on focc_pkg, focc_angle, focc_sat, focc_color.

// Usage
//   An item (dx_offset_i, dy_offset_i) is transferred at each rising edge
//   with start high and busy low. busy stays low: a new item may be started
//   in every cycle, so the block sustains one item per clock.
//   The color leaves on red_o, green_o and blue_o with done_o high for one
//   cycle. The depth is set by the 28-stage square root (12-bit offsets)
//   and 17-stage divider of the saturation path; the hue path is delayed
//   to match.
//   Items come out in order, one per started item.
//   The receiver cannot stall the block, and none is needed: results are
//   spaced exactly as the starts were.
//   Registers over APB: offset 0x0 saturation radius (12 bits, 0 acts as 1),
//   offset 0x4 brightness level (8 bits). Write them only while no item is
//   in flight.
//   Reset clears all in-flight items and sets radius 40 and level 204.

module flow_offset_to_rgb_color (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [focc_pkg::OFFSET_BITS-1:0] dx_offset_i,
  input  logic signed [focc_pkg::OFFSET_BITS-1:0] dy_offset_i,
  output logic                               done_o,
  output logic [focc_pkg::CH_W-1:0]          red_o,
  output logic [focc_pkg::CH_W-1:0]          green_o,
  output logic [focc_pkg::CH_W-1:0]          blue_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [focc_pkg::PADDR_W-1:0]       paddr,
  input  logic [focc_pkg::PDATA_W-1:0]       pwdata,
  output logic [focc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import focc_pkg::*;

  logic [RAD_W-1:0] radius_q;
  logic [LVL_W-1:0] level_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  logic                          in_vld_q;
  logic signed [OFFSET_BITS-1:0] dx_q, dy_q;
  logic [ABS_W-1:0]              ax, ay;
  quad_t                         quad;

  logic             ang_vld;
  logic [HUE_W-1:0] ang_hue;
  logic             sat_vld;
  logic [S_W-1:0]   sat_s;
  logic [HUE_W-1:0] hue_dly_q [HUE_DLY];

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      level_q  <= LEVEL_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
        REG_LEVEL:  level_q  <= pwdata[LVL_W-1:0];
        default:    radius_q <= radius_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = PDATA_W'(radius_q);
      REG_LEVEL:  prdata = PDATA_W'(level_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_offset_i;
    dy_q <= dy_offset_i;
  end

  // The most negative offset maps to 2^(W-1), which still fits unsigned.
  assign ax = dx_q[OFFSET_BITS-1] ? ABS_W'(~dx_q) + ABS_W'(1) : ABS_W'(dx_q);
  assign ay = dy_q[OFFSET_BITS-1] ? ABS_W'(~dy_q) + ABS_W'(1) : ABS_W'(dy_q);

  assign quad.dx_neg  = dx_q[OFFSET_BITS-1];
  assign quad.dy_neg  = dy_q[OFFSET_BITS-1];
  assign quad.dx_zero = (dx_q == '0);
  assign quad.dy_zero = (dy_q == '0);

  focc_angle u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld_q),
    .ax_i   (ax),
    .ay_i   (ay),
    .quad_i (quad),
    .vld_o  (ang_vld),
    .hue_o  (ang_hue)
  );

  focc_sat u_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (in_vld_q),
    .ax_i     (ax),
    .ay_i     (ay),
    .radius_i (radius_q),
    .vld_o    (sat_vld),
    .s_o      (sat_s)
  );

  // Hue waits here until the saturation of the same item is ready.
  always_ff @(posedge clk_i) begin
    hue_dly_q[0] <= ang_hue;
    for (int unsigned i = 1; i < HUE_DLY; i++) begin
      hue_dly_q[i] <= hue_dly_q[i-1];
    end
  end

  focc_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (sat_vld),
    .hue_i   (hue_dly_q[HUE_DLY-1]),
    .s_i     (sat_s),
    .level_i (level_q),
    .vld_o   (done_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT_TOTAL done_o)
    else $error("started item did not complete after the pipeline depth");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT_TOTAL))
    else $error("result strobe without a matching start");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_vld |-> (sat_s <= ONE_Q16))
    else $error("saturation above one");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ang_vld |-> (ang_hue < DEG_Q8_360))
    else $error("hue outside 0 to 360 degrees");

endmodule

[src/focc_angle.sv]
// Hue pipeline: 16-step vectoring CORDIC, rounding and quadrant mapping.
// Depends on focc_pkg.

module focc_angle (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [focc_pkg::ABS_W-1:0] ax_i,
  input  logic [focc_pkg::ABS_W-1:0] ay_i,
  input  focc_pkg::quad_t            quad_i,
  output logic                       vld_o,
  output logic [focc_pkg::HUE_W-1:0] hue_o
);
  import focc_pkg::*;

  logic                    vld_q  [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  x_q    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  y_q    [CORDIC_STEPS+1];
  logic        [Z_W-1:0]   z_q    [CORDIC_STEPS+1];
  quad_t                   quad_q [CORDIC_STEPS+1];

  logic             ang_vld_q;
  logic [ANG_W-1:0] ang_q, ang_d;
  quad_t            ang_quad_q;
  logic [HUE_W-1:0] hue_q, hue_d;
  logic             hue_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= signed'({3'b000, ax_i, 16'h0000});
    y_q[0]    <= signed'({3'b000, ay_i, 16'h0000});
    z_q[0]    <= '0;
    quad_q[0] <= quad_i;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] xs, ys;
    logic                   y_pos;

    assign xs    = x_q[i] >>> i;
    assign ys    = y_q[i] >>> i;
    assign y_pos = !y_q[i][XY_W-1] && (y_q[i] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      quad_q[i+1] <= quad_q[i];
      if (y_pos) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + ATAN_DEG_Q16[i];
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - ATAN_DEG_Q16[i];
      end
    end
  end

  // Clamp the accumulator to 0..90 degrees, then round half up to Q8.
  always_comb begin
    logic [Z_W-1:0] zc;
    logic [Z_W-1:0] zr;
    if (z_q[CORDIC_STEPS][Z_W-1]) begin
      zc = '0;
    end else if (z_q[CORDIC_STEPS] > Z_MAX_DEG90) begin
      zc = Z_MAX_DEG90;
    end else begin
      zc = z_q[CORDIC_STEPS];
    end
    zr = zc + Z_HALF_LSB;
    if (quad_q[CORDIC_STEPS].dx_zero) begin
      ang_d = ANG_Q8_90;
    end else if (quad_q[CORDIC_STEPS].dy_zero) begin
      ang_d = '0;
    end else begin
      ang_d = zr[ANG_W+7:8];
    end
  end

  always_comb begin
    logic [HUE_W-1:0] a;
    a = HUE_W'(ang_q);
    if (!ang_quad_q.dx_neg && !ang_quad_q.dy_neg) begin
      hue_d = a;
    end else if (!ang_quad_q.dy_neg) begin
      hue_d = DEG_Q8_180 - a;
    end else if (ang_quad_q.dx_neg) begin
      hue_d = DEG_Q8_180 + a;
    end else if (a == '0) begin
      hue_d = '0;
    end else begin
      hue_d = DEG_Q8_360 - a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= 1'b0;
      hue_vld_q <= 1'b0;
    end else begin
      ang_vld_q <= vld_q[CORDIC_STEPS];
      hue_vld_q <= ang_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q      <= ang_d;
    ang_quad_q <= quad_q[CORDIC_STEPS];
    hue_q      <= hue_d;
  end

  assign vld_o = hue_vld_q;
  assign hue_o = hue_q;

endmodule

[src/focc_sat.sv]
// Saturation pipeline: squared length, digit-by-digit square root and
// restoring division by the radius. Depends on focc_pkg.

module focc_sat (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [focc_pkg::ABS_W-1:0] ax_i,
  input  logic [focc_pkg::ABS_W-1:0] ay_i,
  input  logic [focc_pkg::RAD_W-1:0] radius_i,
  output logic                       vld_o,
  output logic [focc_pkg::S_W-1:0]   s_o
);
  import focc_pkg::*;

  logic                 sq_vld_q [ROOT_W+1];
  logic [L2_W-1:0]      l2_q     [ROOT_W+1];
  logic [SQREM_W-1:0]   rem_q    [1:ROOT_W];
  logic [ROOT_W-1:0]    root_q   [1:ROOT_W];

  logic                 dv_vld_q [QUO_BITS+1];
  logic                 ovf_q    [QUO_BITS+1];
  logic [QUO_BITS-1:0]  num_q    [QUO_BITS+1];
  logic [DREM_W-1:0]    drem_q   [QUO_BITS+1];
  logic [QUO_BITS-1:0]  quo_q    [QUO_BITS+1];

  logic [RAD_W-1:0]     rad;
  logic [ROOT_W-1:0]    root_fin;
  logic                 ovf_d;
  logic                 s_vld_q;
  logic [S_W-1:0]       s_q, s_d;

  assign rad = (radius_i == '0) ? RAD_W'(1) : radius_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    l2_q[0] <= L2_W'(ax_i * ax_i) + L2_W'(ay_i * ay_i);
  end

  // One result bit per stage; the radicand is l2 followed by 32 zero bits.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [2*ROOT_W-1:0] rad_full;
    logic [SQREM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]   root_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
    end

    assign rad_full = {l2_q[k], 32'h0};
    assign rem_sh   = {rem_in[SQREM_W-3:0], rad_full[2*ROOT_W-1-2*k -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      l2_q[k+1] <= l2_q[k];
      if (rem_sh >= trial) begin
        rem_q[k+1]  <= rem_sh - trial;
        root_q[k+1] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[k+1]  <= rem_sh;
        root_q[k+1] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // A quotient of 2^17 or more saturates, so only 17 quotient bits are formed.
  assign root_fin = root_q[ROOT_W];
  assign ovf_d = (RAD_W + ROOT_W + QUO_BITS)'(root_fin) >=
                 (RAD_W + ROOT_W + QUO_BITS)'({rad, {QUO_BITS{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= sq_vld_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= ovf_d;
    num_q[0]  <= root_fin[QUO_BITS-1:0];
    drem_q[0] <= DREM_W'(root_fin >> QUO_BITS);
    quo_q[0]  <= '0;
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    logic [DREM_W-1:0] rem_sh;
    logic              ge;

    assign rem_sh = {drem_q[j][DREM_W-2:0], num_q[j][QUO_BITS-1-j]};
    assign ge     = rem_sh >= {1'b0, rad};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[j+1]  <= ovf_q[j];
      num_q[j+1]  <= num_q[j];
      drem_q[j+1] <= ge ? rem_sh - {1'b0, rad} : rem_sh;
      quo_q[j+1]  <= {quo_q[j][QUO_BITS-2:0], ge};
    end
  end

  assign s_d = (ovf_q[QUO_BITS] || (quo_q[QUO_BITS] > ONE_Q16)) ? ONE_Q16
                                                                : quo_q[QUO_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= dv_vld_q[QUO_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign vld_o = s_vld_q;
  assign s_o   = s_q;

endmodule

[src/focc_color.sv]
// Six-sector HSV to RGB conversion: sector split, hue fraction, products
// and channel selection. Depends on focc_pkg.

module focc_color (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [focc_pkg::HUE_W-1:0] hue_i,
  input  logic [focc_pkg::S_W-1:0]   s_i,
  input  logic [focc_pkg::LVL_W-1:0] level_i,
  output logic                       vld_o,
  output logic [focc_pkg::CH_W-1:0]  red_o,
  output logic [focc_pkg::CH_W-1:0]  green_o,
  output logic [focc_pkg::CH_W-1:0]  blue_o
);
  import focc_pkg::*;

  logic [LAT_COLOR-1:0] vld_q;

  // Stage 0
  sector_e          sec0_q, sec0_d;
  logic [NUM_W-1:0] num0_q;
  logic [S_W-1:0]   s0_q;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] hrem;

  // Stage 1
  sector_e               sec1_q;
  logic [NUM_W-1:0]      num1_q;
  logic [F_W-1:0]        q0_q;
  logic [S_W-1:0]        s1_q;
  logic [NUM_W+RCP_W-1:0] rprod;

  // Stage 2
  sector_e          sec2_q;
  logic [F_W-1:0]   f_q;
  logic [S_W-1:0]   s2_q;
  logic [NUM_W-1:0] chk;

  // Stage 3
  sector_e              sec3_q;
  logic [S_W-1:0]       fs_q;
  logic [S_W-1:0]       s3_q;
  logic [F_W+S_W-1:0]   fprod;

  // Stage 4
  sector_e              sec4_q;
  logic [CH_W-1:0]      p_q, q_q, t_q, v_q;
  logic [LVL_W+S_W-1:0] pprod, qprod, tprod;

  // Stage 5
  logic [CH_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT_COLOR-2:0], vld_i};
    end
  end

  always_comb begin
    if (hue_i >= DEG_Q8_300) begin
      sec0_d = SEC_MAGENTA_RED;
      base   = DEG_Q8_300;
    end else if (hue_i >= DEG_Q8_240) begin
      sec0_d = SEC_BLUE_MAGENTA;
      base   = DEG_Q8_240;
    end else if (hue_i >= DEG_Q8_180) begin
      sec0_d = SEC_CYAN_BLUE;
      base   = DEG_Q8_180;
    end else if (hue_i >= DEG_Q8_120) begin
      sec0_d = SEC_GREEN_CYAN;
      base   = DEG_Q8_120;
    end else if (hue_i >= DEG_Q8_60) begin
      sec0_d = SEC_YELLOW_GREEN;
      base   = DEG_Q8_60;
    end else begin
      sec0_d = SEC_RED_YELLOW;
      base   = '0;
    end
    hrem = hue_i - base;
  end

  // f = floor(rem * 2^16 / 15360) = floor(rem * 64 / 15).
  assign rprod = (NUM_W + RCP_W)'(num0_q) * (NUM_W + RCP_W)'(RECIP_15);
  assign chk   = num1_q - NUM_W'({q0_q, 4'h0}) + NUM_W'(q0_q);
  assign fprod = (F_W + S_W)'(f_q) * (F_W + S_W)'(s2_q);
  assign pprod = (LVL_W + S_W)'(level_i) * (LVL_W + S_W)'(ONE_Q16 - s3_q);
  assign qprod = (LVL_W + S_W)'(level_i) * (LVL_W + S_W)'(ONE_Q16 - fs_q);
  assign tprod = (LVL_W + S_W)'(level_i) * (LVL_W + S_W)'(ONE_Q16 - (s3_q - fs_q));

  always_ff @(posedge clk_i) begin
    sec0_q <= sec0_d;
    num0_q <= {hrem[NUM_W-7:0], 6'b000000};
    s0_q   <= s_i;

    sec1_q <= sec0_q;
    num1_q <= num0_q;
    q0_q   <= rprod[F_W+23:24];
    s1_q   <= s0_q;

    sec2_q <= sec1_q;
    f_q    <= (chk >= FIFTEEN) ? q0_q + F_W'(1) : q0_q;
    s2_q   <= s1_q;

    sec3_q <= sec2_q;
    fs_q   <= fprod[S_W+15:16];
    s3_q   <= s2_q;

    sec4_q <= sec3_q;
    p_q    <= pprod[CH_W+15:16];
    q_q    <= qprod[CH_W+15:16];
    t_q    <= tprod[CH_W+15:16];
    v_q    <= level_i;

    case (sec4_q)
      SEC_RED_YELLOW: begin
        red_q <= v_q; green_q <= t_q; blue_q <= p_q;
      end
      SEC_YELLOW_GREEN: begin
        red_q <= q_q; green_q <= v_q; blue_q <= p_q;
      end
      SEC_GREEN_CYAN: begin
        red_q <= p_q; green_q <= v_q; blue_q <= t_q;
      end
      SEC_CYAN_BLUE: begin
        red_q <= p_q; green_q <= q_q; blue_q <= v_q;
      end
      SEC_BLUE_MAGENTA: begin
        red_q <= t_q; green_q <= p_q; blue_q <= v_q;
      end
      default: begin
        red_q <= v_q; green_q <= p_q; blue_q <= q_q;
      end
    endcase
  end

  assign vld_o   = vld_q[LAT_COLOR-1];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

[verif/testbench.sv]
// Self-checking testbench for flow_offset_to_rgb_color: drives displacements,
// predicts each RGB color with a fixed-point HSV model and checks every result.
// Depends on focc_pkg and the flow_offset_to_rgb_color RTL.

class color_scoreboard;
  logic [7:0] exp_r[$];
  logic [7:0] exp_g[$];
  logic [7:0] exp_b[$];
  int         mismatches;

  function void note_input(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    exp_r.push_back(r);
    exp_g.push_back(g);
    exp_b.push_back(b);
  endfunction

  function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [7:0] er, eg, eb;
    if (exp_r.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected color %0d %0d %0d", r, g, b);
      return;
    end
    er = exp_r.pop_front();
    eg = exp_g.pop_front();
    eb = exp_b.pop_front();
    if (r !== er || g !== eg || b !== eb) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Color mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                 er, eg, eb, r, g, b);
    end
  endfunction

  function int pending();
    return exp_r.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import focc_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [OFFSET_BITS-1:0] dx_offset_i = '0;
  logic signed [OFFSET_BITS-1:0] dy_offset_i = '0;
  logic                          done_o;
  logic [CH_W-1:0]               red_o, green_o, blue_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_W-1:0]            paddr = '0;
  logic [PDATA_W-1:0]            pwdata = '0;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;

  color_scoreboard colors = new();
  int unsigned radius_reg = 40;
  int unsigned level_reg = 204;
  int          cycle_count = 0;

  always #4 clk_i = ~clk_i;

  flow_offset_to_rgb_color u_dut (
    .clk_i, .rst_ni, .start, .busy, .dx_offset_i, .dy_offset_i, .done_o,
    .red_o, .green_o, .blue_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring-mode CORDIC on the absolute offsets, degrees with 8 fraction bits.
  function automatic longint first_quadrant_angle(longint ax, longint ay);
    longint x = ax <<< 16;
    longint y = ay <<< 16;
    longint z = 0;
    longint xs, ys;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      ys = floor_shift(y, i);
      xs = floor_shift(x, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ATAN_DEG_Q16[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_DEG_Q16[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    z = (z + 128) >>> 8;
    if (z > 23040) z = 23040;
    return z;
  endfunction

  function automatic void predict_color(int dx, int dy, output logic [7:0] r,
                                        output logic [7:0] g, output logic [7:0] b);
    longint ax, ay, ang, hue;
    longint unsigned l2, sat, rad, frac, fs, lv, p, q, t, rem;
    sector_e sec;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (dx == 0) ang = 23040;
    else if (dy == 0) ang = 0;
    else ang = first_quadrant_angle(ax, ay);
    if (dx >= 0 && dy >= 0) hue = ang;
    else if (dx < 0 && dy >= 0) hue = 46080 - ang;
    else if (dx < 0) hue = 46080 + ang;
    else hue = 92160 - ang;
    if (hue >= 92160) hue -= 92160;
    l2 = ax * ax + ay * ay;
    rad = radius_reg == 0 ? 1 : radius_reg;
    sat = int_sqrt(l2 << 32) / rad;
    if (sat > 65536) sat = 65536;
    sec = sector_e'(hue / 15360);
    rem = hue - (hue / 15360) * 15360;
    frac = (rem << 16) / 15360;
    fs = (frac * sat) >> 16;
    lv = level_reg;
    p = (lv * (65536 - sat)) >> 16;
    q = (lv * (65536 - fs)) >> 16;
    t = (lv * (65536 - (sat - fs))) >> 16;
    case (sec)
      SEC_RED_YELLOW:   begin r = 8'(lv); g = 8'(t);  b = 8'(p);  end
      SEC_YELLOW_GREEN: begin r = 8'(q);  g = 8'(lv); b = 8'(p);  end
      SEC_GREEN_CYAN:   begin r = 8'(p);  g = 8'(lv); b = 8'(t);  end
      SEC_CYAN_BLUE:    begin r = 8'(p);  g = 8'(q);  b = 8'(lv); end
      SEC_BLUE_MAGENTA: begin r = 8'(t);  g = 8'(p);  b = 8'(lv); end
      default:          begin r = 8'(lv); g = 8'(p);  b = 8'(q);  end
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) colors.check_color(red_o, green_o, blue_o);
  end

  always @(posedge clk_i) begin
    if (cycle_count >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(idx) * 4); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_RADIUS) radius_reg = value[11:0];
    else level_reg = value[7:0];
    @(posedge clk_i);
  endtask

  task automatic send_offset(int dx, int dy, int gap);
    logic [7:0] r, g, b;
    logic signed [OFFSET_BITS-1:0] dx_s, dy_s;
    dx_s = dx[OFFSET_BITS-1:0];
    dy_s = dy[OFFSET_BITS-1:0];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    dx_offset_i <= dx_s;
    dy_offset_i <= dy_s;
    do @(posedge clk_i); while (busy);
    // Offsets outside the field wrap as they do on the ports.
    predict_color(int'(dx_s), int'(dy_s), r, g, b);
    colors.note_input(r, g, b);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (colors.pending() != 0) @(posedge clk_i);
    repeat (LAT_TOTAL + 5) @(posedge clk_i);
  endtask

  function automatic int rand_offset();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4095) - 2048;
      1: return int'($urandom_range(0, 80)) - 40;
      2: return int'($urandom_range(0, 8)) - 4;
      default: return ($urandom_range(0, 1) ? 2047 : -2048) - int'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    int dirs[24][2] = '{
      '{0, 0}, '{0, 5}, '{0, -5}, '{7, 0}, '{-7, 0}, '{2047, 2047},
      '{-2048, -2048}, '{2047, -2048}, '{-2048, 2047}, '{1, 1}, '{-1, 1},
      '{-1, -1}, '{1, -1}, '{30, 17}, '{-17, 30}, '{-30, -17}, '{17, -30},
      '{5, 20}, '{-20, 5}, '{20, -5}, '{0, -2048}, '{-2048, 0}, '{1365, 2730 / 2},
      '{40, 0}};
    int gap;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dirs[i]) send_offset(dirs[i][0], dirs[i][1], 0);
    drain();
    // Register extremes (radius zero acts as one), random values, reset values.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin write_reg(REG_RADIUS, 0);    write_reg(REG_LEVEL, 255); end
        1: begin write_reg(REG_RADIUS, 4095); write_reg(REG_LEVEL, 0);   end
        2: begin write_reg(REG_RADIUS, 1);    write_reg(REG_LEVEL, 1);   end
        6: begin write_reg(REG_RADIUS, 40);   write_reg(REG_LEVEL, 204); end
        default: begin
          write_reg(REG_RADIUS, $urandom_range(1, 4095));
          write_reg(REG_LEVEL, $urandom_range(0, 255));
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        gap = (n % 40 < 12) ? 0 : $urandom_range(0, 10);
        send_offset(rand_offset(), rand_offset(), gap);
        // Hold off once until the pipeline has emptied.
        if (phase == 3 && n == 50) begin
          start <= 1'b0;
          while (colors.pending() != 0) @(posedge clk_i);
        end
      end
      drain();
    end
    if (colors.mismatches == 0 && colors.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
